// ===== src/smk_pkg.sv =====
package smk_pkg;

    localparam int LEN_W    = 13;
    localparam int DIV_CW   = 4;

    localparam logic [LEN_W-1:0]  MAX_READ_LENGTH = 13'd4096;
    localparam logic [LEN_W-1:0]  POS_MAX         = 13'd8191;
    localparam logic [DIV_CW-1:0] DIV_LAST        = 4'd12;
    localparam logic [3:0]        KMER_MAX        = 4'd8;
    localparam logic [4:0]        SEG_MAX         = 5'd16;

    localparam logic [1:0] CFG_KMER_BYTES    = 2'd0;
    localparam logic [1:0] CFG_BARCODE_BASES = 2'd1;
    localparam logic [1:0] CFG_SEGMENT_COUNT = 2'd2;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_DIV,
        ST_HELD,
        ST_TAIL
    } state_t;

    typedef struct packed {
        logic start_read;
        logic div_step;
        logic step;
        logic use_held;
        logic tail_emit;
        logic end_read;
    } ctrl_cmd_t;

    typedef struct packed {
        logic first_base;
        logic div_done;
        logic out_free;
        logic tail_pending;
        logic held_end;
    } ctrl_status_t;

    function automatic logic [3:0] eff_k(input logic [3:0] raw);
        if (raw == 4'd0) return 4'd1;
        if (raw > KMER_MAX) return KMER_MAX;
        return raw;
    endfunction

    function automatic logic [4:0] eff_count(input logic [4:0] raw);
        if (raw == 5'd0) return 5'd1;
        if (raw > SEG_MAX) return SEG_MAX;
        return raw;
    endfunction

    function automatic logic [63:0] kmer_mask(input logic [3:0] k);
        logic [63:0] m;
        unique case (k)
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd3:    m = 64'h0000_0000_00FF_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            4'd5:    m = 64'h0000_00FF_FFFF_FFFF;
            4'd6:    m = 64'h0000_FFFF_FFFF_FFFF;
            4'd7:    m = 64'h00FF_FFFF_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

// ===== src/smk_ctrl.sv =====
module smk_ctrl
    import smk_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         read_end,
    input  ctrl_status_t status,
    output logic         in_ready,
    output ctrl_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && status.out_free && (state_reg == ST_RUN);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (accept)
                begin
                    if (status.first_base)
                        state_next = ST_DIV;
                    else if (read_end)
                        state_next = ST_TAIL;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_HELD;
            end
            ST_HELD:
            begin
                if (status.out_free)
                    state_next = status.held_end ? ST_TAIL : ST_RUN;
            end
            ST_TAIL:
            begin
                if (!status.tail_pending)
                    state_next = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready       = status.out_free;
                cmd.start_read = accept && status.first_base;
                cmd.step       = accept && !status.first_base;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_HELD:
            begin
                cmd.step     = status.out_free;
                cmd.use_held = 1'b1;
            end
            ST_TAIL:
            begin
                cmd.tail_emit = status.tail_pending && status.out_free;
                cmd.end_read  = !status.tail_pending;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_RUN;
        else
            state_reg <= state_next;
    end

endmodule

// ===== src/smk_datapath.sv =====
module smk_datapath
    import smk_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [7:0]         cfg_data,
    input  logic [7:0]         base_byte,
    input  logic [LEN_W-1:0]   read_length,
    input  logic               read_end,
    input  logic               out_ready,
    input  ctrl_cmd_t          cmd,
    output ctrl_status_t       status,
    output logic               out_valid,
    output logic [63:0]        minimizer_value,
    output logic [3:0]         segment_index,
    output logic               run_last
);

    logic [3:0]        kmer_bytes_reg, kmer_bytes_next;
    logic [7:0]        barcode_bases_reg, barcode_bases_next;
    logic [4:0]        segment_count_reg, segment_count_next;

    logic [63:0]       window_reg, window_next;
    logic [63:0]       min_reg, min_next;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  seg_len_reg, seg_len_next;
    logic [LEN_W-1:0]  in_seg_reg, in_seg_next;
    logic [4:0]        cur_seg_reg, cur_seg_next;

    logic [LEN_W-1:0]  dividend_reg, dividend_next;
    logic [4:0]        rem_reg, rem_next;
    logic [DIV_CW-1:0] div_cnt_reg, div_cnt_next;

    logic [7:0]        hold_byte_reg, hold_byte_next;
    logic              hold_end_reg, hold_end_next;

    logic              out_valid_reg, out_valid_next;
    logic [63:0]       value_reg, value_next;
    logic [3:0]        index_reg, index_next;
    logic              last_reg, last_next;

    logic [3:0]        k;
    logic [4:0]        cnt;
    logic [LEN_W-1:0]  bc;
    logic [LEN_W-1:0]  k_ext;
    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  dividend_init;
    logic [7:0]        step_byte;
    logic              active;
    logic [63:0]       win_shift;
    logic [LEN_W-1:0]  in_seg_inc;
    logic [63:0]       min_cand;
    logic              seg_done;
    logic              step_emit;
    logic              load_out;
    logic              seg_last;
    logic              out_free;
    logic [5:0]        rem_shift;
    logic              rem_ge;
    logic [5:0]        rem_sub;

    assign k             = eff_k(kmer_bytes_reg);
    assign cnt           = eff_count(segment_count_reg);
    assign bc            = {{(LEN_W-8){1'b0}}, barcode_bases_reg};
    assign k_ext         = {{(LEN_W-4){1'b0}}, k};
    assign len_sat       = (read_length > MAX_READ_LENGTH) ? MAX_READ_LENGTH : read_length;
    assign dividend_init = (len_sat > bc) ? len_sat - bc : '0;

    assign step_byte  = cmd.use_held ? hold_byte_reg : base_byte;
    assign active     = (pos_reg >= bc) && (seg_len_reg >= k_ext) && (cur_seg_reg < cnt);
    assign win_shift  = {window_reg[55:0], step_byte} & kmer_mask(k);
    assign in_seg_inc = in_seg_reg + {{(LEN_W-1){1'b0}}, 1'b1};
    assign min_cand   = ((in_seg_inc >= k_ext) && (win_shift < min_reg)) ? win_shift : min_reg;
    assign seg_done   = in_seg_inc >= seg_len_reg;
    assign step_emit  = cmd.step && active && seg_done;
    assign load_out   = step_emit || cmd.tail_emit;
    assign seg_last   = (cur_seg_reg + 5'd1) == cnt;
    assign out_free   = !out_valid_reg || out_ready;

    assign rem_shift = {rem_reg, dividend_reg[LEN_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, cnt};
    assign rem_sub   = rem_ge ? rem_shift - {1'b0, cnt} : rem_shift;

    assign status.first_base   = pos_reg == '0;
    assign status.div_done     = div_cnt_reg == DIV_LAST;
    assign status.out_free     = out_free;
    assign status.tail_pending = cur_seg_reg < cnt;
    assign status.held_end     = hold_end_reg;

    always_comb
    begin
        kmer_bytes_next    = kmer_bytes_reg;
        barcode_bases_next = barcode_bases_reg;
        segment_count_next = segment_count_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KMER_BYTES:    kmer_bytes_next    = cfg_data[3:0];
                CFG_BARCODE_BASES: barcode_bases_next = cfg_data;
                CFG_SEGMENT_COUNT: segment_count_next = cfg_data[4:0];
                default:           kmer_bytes_next    = kmer_bytes_reg;
            endcase
        end
    end

    always_comb
    begin
        window_next   = window_reg;
        min_next      = min_reg;
        pos_next      = pos_reg;
        seg_len_next  = seg_len_reg;
        in_seg_next   = in_seg_reg;
        cur_seg_next  = cur_seg_reg;
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        div_cnt_next  = div_cnt_reg;
        hold_byte_next = hold_byte_reg;
        hold_end_next  = hold_end_reg;

        if (cmd.start_read)
        begin
            hold_byte_next = base_byte;
            hold_end_next  = read_end;
            dividend_next  = dividend_init;
            rem_next       = '0;
            div_cnt_next   = '0;
            seg_len_next   = '0;
            cur_seg_next   = '0;
            window_next    = '0;
            min_next       = '1;
            in_seg_next    = '0;
        end

        if (cmd.div_step)
        begin
            dividend_next = {dividend_reg[LEN_W-2:0], 1'b0};
            rem_next      = rem_sub[4:0];
            seg_len_next  = {seg_len_reg[LEN_W-2:0], rem_ge};
            div_cnt_next  = div_cnt_reg + {{(DIV_CW-1){1'b0}}, 1'b1};
        end

        if (cmd.step)
        begin
            if (active)
            begin
                if (seg_done)
                begin
                    cur_seg_next = cur_seg_reg + 5'd1;
                    window_next  = '0;
                    min_next     = '1;
                    in_seg_next  = '0;
                end
                else
                begin
                    window_next = win_shift;
                    min_next    = min_cand;
                    in_seg_next = in_seg_inc;
                end
            end
            if (pos_reg < POS_MAX)
                pos_next = pos_reg + {{(LEN_W-1){1'b0}}, 1'b1};
        end

        if (cmd.tail_emit)
            cur_seg_next = cur_seg_reg + 5'd1;

        if (cmd.end_read)
        begin
            pos_next     = '0;
            cur_seg_next = '0;
            window_next  = '0;
            min_next     = '1;
            in_seg_next  = '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            value_next     = cmd.tail_emit ? '1 : min_cand;
            index_next     = cur_seg_reg[3:0];
            last_next      = seg_last;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_bytes_reg    <= 4'd8;
            barcode_bases_reg <= 8'd8;
            segment_count_reg <= 5'd4;
            window_reg        <= '0;
            min_reg           <= '1;
            pos_reg           <= '0;
            seg_len_reg       <= '0;
            in_seg_reg        <= '0;
            cur_seg_reg       <= '0;
            div_cnt_reg       <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            kmer_bytes_reg    <= kmer_bytes_next;
            barcode_bases_reg <= barcode_bases_next;
            segment_count_reg <= segment_count_next;
            window_reg        <= window_next;
            min_reg           <= min_next;
            pos_reg           <= pos_next;
            seg_len_reg       <= seg_len_next;
            in_seg_reg        <= in_seg_next;
            cur_seg_reg       <= cur_seg_next;
            div_cnt_reg       <= div_cnt_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg  <= dividend_next;
        rem_reg       <= rem_next;
        hold_byte_reg <= hold_byte_next;
        hold_end_reg  <= hold_end_next;
        value_reg     <= value_next;
        index_reg     <= index_next;
        last_reg      <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign minimizer_value = value_reg;
    assign segment_index   = index_reg;
    assign run_last        = last_reg;

endmodule

// ===== src/segmented_kmer_minimizer.sv =====
// Per-segment k-mer minimizer over a read streamed one base byte per item.
// Input channel (in_valid/in_ready): base_byte, read_length, read_end; the
// read length is taken from the first base of each read.
// Output channel (out_valid/out_ready): minimizer_value, segment_index,
// run_last; one item per segment, run_last on the final segment of a read.
// Config port: cfg_we, cfg_index, cfg_data; write only while idle.
// Throughput: one base per cycle inside a read, while the output can take
// a result. The first base of a read is held while a one-bit-per-cycle
// divider computes the segment length, then processed from the hold register.
// At read_end, segments not yet reported are sent as all ones, one per
// cycle while the output drains; after that the read state is cleared before
// input resumes, also when none are left at read_end.
// Latency: a result appears in the output register the cycle after the
// base that closes its segment is processed.
// Stall: a single output register holds the result; input is taken only
// while that register is empty or being drained, so nothing is lost.
// Reset: kmer_bytes 8, barcode_bases 8, segment_count 4, output empty,
// block ready for the first base of a read.
module segmented_kmer_minimizer
    import smk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [7:0]       cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       base_byte,
    input  logic [LEN_W-1:0] read_length,
    input  logic             read_end,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      minimizer_value,
    output logic [3:0]       segment_index,
    output logic             run_last
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    smk_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .read_end (read_end),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    smk_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .base_byte       (base_byte),
        .read_length     (read_length),
        .read_end        (read_end),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .minimizer_value (minimizer_value),
        .segment_index   (segment_index),
        .run_last        (run_last)
    );

endmodule

// ===== tb/segmented_kmer_minimizer_tb.sv =====
`timescale 1ns / 100ps

module segmented_kmer_minimizer_tb
    import smk_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned SETTLE_CYCLES = 40;
    localparam int unsigned HOLD_CYCLES  = 300;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [7:0]       b;
        logic [LEN_W-1:0] len;
        logic             fin;
    } base_item_t;

    typedef struct {
        logic [63:0] value;
        logic [3:0]  seg;
        logic        last;
    } minimizer_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [1:0]       cfg_index = CFG_KMER_BYTES;
    logic [7:0]       cfg_data = 8'd0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       base_byte = 8'd0;
    logic [LEN_W-1:0] read_length = '0;
    logic             read_end = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [63:0]      minimizer_value;
    logic [3:0]       segment_index;
    logic             run_last;

    base_item_t  bases_to_send[$];
    minimizer_t  minimizers_due[$];
    base_item_t  next_base;
    minimizer_t  due_item;
    idle_mode_t  idle_mode = IDLE_NONE;
    logic        rx_hold = 1'b0;
    int unsigned errors = 0;
    int unsigned cycle_count = 0;

    // predictor copy of the registers and the per-read state
    logic [3:0]  cfg_k = 4'd8;
    logic [7:0]  cfg_bc = 8'd8;
    logic [4:0]  cfg_cnt = 5'd4;
    logic [63:0] window = 64'd0;
    logic [63:0] seg_min = '1;
    int unsigned pos = 0;
    int unsigned seg_len = 0;
    int unsigned in_seg = 0;
    int unsigned cur_seg = 0;

    segmented_kmer_minimizer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .base_byte       (base_byte),
        .read_length     (read_length),
        .read_end        (read_end),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .minimizer_value (minimizer_value),
        .segment_index   (segment_index),
        .run_last        (run_last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic pause_now(input logic sender_side);
        int unsigned pct;
        pct = 0;
        if (idle_mode == IDLE_BOTH)
            pct = 12;
        else if (sender_side && idle_mode == IDLE_SENDER)
            pct = 57;
        else if (!sender_side && idle_mode == IDLE_RECEIVER)
            pct = 57;
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic owe_minimizer(input logic [63:0] value, input int unsigned nseg);
        minimizer_t m;
        m.value = value;
        m.seg = cur_seg[3:0];
        m.last = (cur_seg + 1 == nseg);
        minimizers_due = {minimizers_due, m};
    endtask

    task automatic track_base(input logic [7:0] b, input logic [LEN_W-1:0] len_in,
                              input logic fin);
        int unsigned keff;
        int unsigned nseg;
        int unsigned len;
        logic [63:0] mask;
        keff = (cfg_k == 4'd0) ? 1 : (cfg_k > KMER_MAX) ? KMER_MAX : cfg_k;
        nseg = (cfg_cnt == 5'd0) ? 1 : (cfg_cnt > SEG_MAX) ? SEG_MAX : cfg_cnt;
        len = len_in;
        if (pos == 0)
        begin
            if (len > MAX_READ_LENGTH)
                len = MAX_READ_LENGTH;
            seg_len = (len > cfg_bc) ? (len - cfg_bc) / nseg : 0;
            cur_seg = 0;
            window = 64'd0;
            seg_min = '1;
            in_seg = 0;
        end
        if (pos >= cfg_bc && seg_len >= keff && cur_seg < nseg)
        begin
            mask = (keff >= 8) ? {64{1'b1}} : ((64'd1 << (8 * keff)) - 64'd1);
            window = ((window << 8) | {56'd0, b}) & mask;
            in_seg++;
            if (in_seg >= keff && window < seg_min)
                seg_min = window;
            if (in_seg >= seg_len)
            begin
                owe_minimizer(seg_min, nseg);
                cur_seg++;
                window = 64'd0;
                seg_min = '1;
                in_seg = 0;
            end
        end
        if (pos < POS_MAX)
            pos++;
        if (fin)
        begin
            while (cur_seg < nseg)
            begin
                owe_minimizer('1, nseg);
                cur_seg++;
            end
            pos = 0;
            cur_seg = 0;
            window = 64'd0;
            seg_min = '1;
            in_seg = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                track_base(base_byte, read_length, read_end);
            if (!in_valid || in_ready)
            begin
                if (bases_to_send.size() > 0 && !pause_now(1'b1))
                begin
                    next_base = bases_to_send.pop_front();
                    in_valid <= 1'b1;
                    base_byte <= next_base.b;
                    read_length <= next_base.len;
                    read_end <= next_base.fin;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (minimizers_due.size() == 0)
                begin
                    $display("%0t: unexpected item value %h segment %0d last %0b",
                             $time, minimizer_value, segment_index, run_last);
                    errors++;
                end
                else
                begin
                    due_item = minimizers_due.pop_front();
                    if (minimizer_value !== due_item.value)
                    begin
                        $display("%0t: minimizer_value expected %h actual %h",
                                 $time, due_item.value, minimizer_value);
                        errors++;
                    end
                    if (segment_index !== due_item.seg)
                    begin
                        $display("%0t: segment_index expected %0d actual %0d",
                                 $time, due_item.seg, segment_index);
                        errors++;
                    end
                    if (run_last !== due_item.last)
                    begin
                        $display("%0t: run_last expected %0b actual %0b",
                                 $time, due_item.last, run_last);
                        errors++;
                    end
                end
            end
            out_ready <= !rx_hold && !pause_now(1'b0);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("segmented_kmer_minimizer_tb failed");
            $finish;
        end
    end

    task automatic queue_base(input logic [7:0] b, input int unsigned len, input logic fin);
        base_item_t it;
        it.b = b;
        it.len = len[LEN_W-1:0];
        it.fin = fin;
        bases_to_send = {bases_to_send, it};
    endtask

    task automatic queue_read(input int unsigned len, input int unsigned n_bases);
        for (int unsigned i = 0; i < n_bases; i++)
            queue_base(8'($urandom_range(0, 255)), len, i == n_bases - 1);
    endtask

    // sample after the clock edge has settled so a pending item is never missed
    task automatic wait_idle();
        @(negedge clk);
        while (bases_to_send.size() > 0 || in_valid || minimizers_due.size() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] k, input logic [7:0] bc, input logic [7:0] cnt);
        cfg_we <= 1'b1;
        cfg_index <= CFG_KMER_BYTES;
        cfg_data <= k;
        @(posedge clk);
        cfg_index <= CFG_BARCODE_BASES;
        cfg_data <= bc;
        @(posedge clk);
        cfg_index <= CFG_SEGMENT_COUNT;
        cfg_data <= cnt;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_k = k[3:0];
        cfg_bc = bc;
        cfg_cnt = cnt[4:0];
    endtask

    initial
    begin
        int unsigned k_raw;
        int unsigned bc_raw;
        int unsigned cnt_raw;
        int unsigned seglen;
        int unsigned full_len;
        int unsigned rd_len;
        int unsigned n_bases;
        int unsigned n_sent;
        int unsigned kind;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read shorter than barcode at reset settings
        idle_mode <= IDLE_BOTH;
        queue_base(8'h41, 3, 1'b0);
        queue_base(8'h43, 3, 1'b0);
        queue_base(8'h47, 3, 1'b1);
        wait_idle();

        set_config(8'd1, 8'd0, 8'd1);
        queue_base(8'h00, 0, 1'b1);
        queue_base(8'hFF, 2, 1'b0);
        queue_base(8'h00, 2, 1'b1);
        wait_idle();

        // k and count of zero, length saturating, read ending early
        set_config(8'd0, 8'd0, 8'd0);
        queue_base(8'h12, 8191, 1'b0);
        queue_base(8'h34, 8191, 1'b0);
        queue_base(8'h56, 8191, 1'b1);
        wait_idle();

        set_config(8'd15, 8'd1, 8'd31);
        queue_base(8'hAA, 20, 1'b0);
        queue_base(8'h55, 20, 1'b1);
        wait_idle();

        // full-width windows, one extra base past the last segment
        set_config(8'd8, 8'd0, 8'd2);
        for (int i = 0; i < 17; i++)
            queue_base((i < 8) ? 8'hFF : 8'h00, 16, i == 16);
        wait_idle();

        // widest barcode, read ending inside it
        idle_mode <= IDLE_RECEIVER;
        set_config(8'd2, 8'd255, 8'd1);
        queue_read(300, 3);
        wait_idle();

        // hold the output, keep offering, then pause until drained
        idle_mode <= IDLE_NONE;
        set_config(8'd1, 8'd0, 8'd12);
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (int i = 0; i < 2; i++)
            queue_read(12, 12);
        wait_idle();
        queue_read(12, 4);
        wait_idle();

        for (int p = 0; p < 4; p++)
        begin
            idle_mode <= idle_mode_t'(p % 4);
            k_raw = $urandom_range(1, 8);
            bc_raw = $urandom_range(0, 4);
            cnt_raw = $urandom_range(1, 4);
            set_config(8'(k_raw), 8'(bc_raw), 8'(cnt_raw));
            n_sent = 0;
            while (n_sent < 6)
            begin
                seglen = k_raw + $urandom_range(0, 1);
                full_len = bc_raw + cnt_raw * seglen;
                kind = $urandom_range(0, 9);
                if (kind <= 6)
                begin
                    rd_len = full_len + $urandom_range(0, cnt_raw - 1);
                    n_bases = rd_len;
                end
                else if (kind == 7)
                begin
                    rd_len = full_len;
                    n_bases = $urandom_range(1, full_len);
                end
                else if (kind == 8)
                begin
                    rd_len = full_len;
                    n_bases = full_len + $urandom_range(1, 5);
                end
                else
                begin
                    rd_len = $urandom_range(0, 8191);
                    n_bases = $urandom_range(1, 4);
                end
                queue_read(rd_len, n_bases);
                n_sent += n_bases;
            end
            wait_idle();
        end

        if (errors == 0)
            $display("segmented_kmer_minimizer_tb passed");
        else
            $display("segmented_kmer_minimizer_tb failed");
        $finish;
    end

endmodule
